/* src/drq_pkg.sv */
// Shared types and constants for the descriptor ring queue.
package drq_pkg;

   localparam int MAX_SLOTS_DEFAULT = 256;
   localparam int SLOT_COUNT_W      = 9;
   localparam int SLOT_COUNT_RESET  = 256;
   localparam int OCC_W             = 8;
   localparam int MIN_SLOTS         = 2;

   typedef enum logic [1:0] {
      ACTION_ENQUEUE      = 2'd0,
      ACTION_DEQUEUE      = 2'd1,
      ACTION_PUBLISH_HEAD = 2'd2,
      ACTION_PUBLISH_TAIL = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [31:0] region;
      logic [31:0] buffer;
      logic [63:0] address;
      logic [31:0] length;
      logic [63:0] flags;
   } descriptor_type;

   // Slot store access for one transfer
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctrl_type;

endpackage

/* src/drq_req_if.sv */
// Request channel: action and descriptor to enqueue.
interface drq_req_if import drq_pkg::*;;
   logic        valid;
   logic        ready;
   action_type  action;
   logic [31:0] in_region;
   logic [31:0] in_buffer;
   logic [63:0] in_address;
   logic [31:0] in_length;
   logic [63:0] in_flags;

   modport source (
      output valid, action, in_region, in_buffer, in_address, in_length, in_flags,
      input  ready
   );
   modport sink (
      input  valid, action, in_region, in_buffer, in_address, in_length, in_flags,
      output ready
   );
endinterface

/* src/drq_rsp_if.sv */
// Response channel: status, dequeued descriptor and occupancy.
interface drq_rsp_if import drq_pkg::*;;
   logic             valid;
   logic             ready;
   status_type       status;
   logic [31:0]      out_region;
   logic [31:0]      out_buffer;
   logic [63:0]      out_address;
   logic [31:0]      out_length;
   logic [63:0]      out_flags;
   logic [OCC_W-1:0] occupancy;

   modport source (
      output valid, status, out_region, out_buffer, out_address, out_length,
             out_flags, occupancy,
      input  ready
   );
   modport sink (
      input  valid, status, out_region, out_buffer, out_address, out_length,
             out_flags, occupancy,
      output ready
   );
endinterface

/* src/descriptor_ring_queue.sv */
// Descriptor ring queue top level: pointer logic, response register, slot store.
//
// Usage:
//  - req_if carries one action per transfer: enqueue a descriptor, dequeue one,
//    publish the private head, or publish the private tail.
//  - rsp_if returns exactly one response per request: status (ok, full on
//    enqueue, empty on dequeue), the dequeued descriptor (zero unless a dequeue
//    succeeded) and the occupancy, published head minus private tail.
//  - csr_wr_en/csr_wr_data set the slot count (clamped to 2..MAX_SLOTS) and
//    clear all four pointers; write it only while no request is outstanding.
// Timing:
//  - The response is valid the cycle after the request transfer. The slot store
//    read is registered into the response stage.
//  - Throughput is one request per cycle while rsp_if.ready is high; the pointers
//    update at the transfer edge, so back-to-back enqueue then dequeue of the same slot is safe.
//  - When rsp_if.ready is low the response holds and req_if.ready drops until
//    the response is taken; it rises again in the cycle it is taken.
// Reset: synchronous; pointers clear, slot count returns to 256, no response
//  pending. Slot contents are not cleared and no clearing pass runs.
module descriptor_ring_queue import drq_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [SLOT_COUNT_W-1:0] csr_wr_data,
   drq_req_if.sink                 req_if,
   drq_rsp_if.source               rsp_if
);

   localparam int PTR_W = $clog2(MAX_SLOTS);
   localparam int CNT_W = PTR_W + 1;
   localparam int CMP_W = (CNT_W > SLOT_COUNT_W) ? CNT_W : SLOT_COUNT_W;

   logic [SLOT_COUNT_W-1:0] slot_count_ff;
   logic [PTR_W-1:0]        priv_head_ff, priv_tail_ff, pub_head_ff, pub_tail_ff;
   logic [PTR_W-1:0]        priv_head_in, priv_tail_in, pub_head_in, pub_tail_in;
   logic                    rsp_valid_ff;
   status_type              status_ff, status_in;
   logic [OCC_W-1:0]        occupancy_ff, occupancy_in;
   logic                    deq_ok_ff;

   logic [CMP_W-1:0] count_ext;
   logic [CNT_W-1:0] ring_n;
   logic [CNT_W-1:0] head_ext, tail_ext, pub_head_ext, pub_tail_ext;
   logic [CNT_W-1:0] head_inc, tail_inc, used_slots, occ_dist;
   logic [CNT_W-1:0] occ_head, occ_tail;
   logic             ring_full, ring_empty, accept;
   ram_ctrl_type     ram_ctrl;
   descriptor_type   wr_desc, rd_desc;

   // Effective ring size
   always_comb begin
      count_ext = CMP_W'(slot_count_ff);
      if (count_ext < CMP_W'(MIN_SLOTS)) begin
         ring_n = CNT_W'(MIN_SLOTS);
      end else if (count_ext > CMP_W'(MAX_SLOTS)) begin
         ring_n = CNT_W'(MAX_SLOTS);
      end else begin
         ring_n = CNT_W'(count_ext);
      end
   end

   assign head_ext     = CNT_W'(priv_head_ff);
   assign tail_ext     = CNT_W'(priv_tail_ff);
   assign pub_head_ext = CNT_W'(pub_head_ff);
   assign pub_tail_ext = CNT_W'(pub_tail_ff);

   assign head_inc = (head_ext + 1'b1 == ring_n) ? '0 : head_ext + 1'b1;
   assign tail_inc = (tail_ext + 1'b1 == ring_n) ? '0 : tail_ext + 1'b1;

   assign used_slots = (head_ext >= pub_tail_ext) ? head_ext - pub_tail_ext
                                                  : head_ext + ring_n - pub_tail_ext;
   assign ring_full  = (used_slots == ring_n - 1'b1);
   assign ring_empty = (pub_head_ff == priv_tail_ff);

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      priv_head_in = priv_head_ff;
      priv_tail_in = priv_tail_ff;
      pub_head_in  = pub_head_ff;
      pub_tail_in  = pub_tail_ff;
      status_in    = STATUS_OK;
      ram_ctrl     = '0;
      unique case (req_if.action)
         ACTION_ENQUEUE: begin
            if (ring_full) begin
               status_in = STATUS_FULL;
            end else begin
               ram_ctrl.wr_en = accept;
               priv_head_in   = PTR_W'(head_inc);
            end
         end
         ACTION_DEQUEUE: begin
            if (ring_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               ram_ctrl.rd_en = accept;
               priv_tail_in   = PTR_W'(tail_inc);
            end
         end
         ACTION_PUBLISH_HEAD: pub_head_in = priv_head_ff;
         ACTION_PUBLISH_TAIL: pub_tail_in = priv_tail_ff;
      endcase
   end

   // Occupancy after this action
   assign occ_head     = CNT_W'(pub_head_in);
   assign occ_tail     = CNT_W'(priv_tail_in);
   assign occ_dist     = (occ_head >= occ_tail) ? occ_head - occ_tail
                                                : occ_head + ring_n - occ_tail;
   assign occupancy_in = OCC_W'(occ_dist);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_W'(SLOT_COUNT_RESET);
         priv_head_ff  <= '0;
         priv_tail_ff  <= '0;
         pub_head_ff   <= '0;
         pub_tail_ff   <= '0;
      end else if (csr_wr_en) begin
         slot_count_ff <= csr_wr_data;
         priv_head_ff  <= '0;
         priv_tail_ff  <= '0;
         pub_head_ff   <= '0;
         pub_tail_ff   <= '0;
      end else if (accept) begin
         priv_head_ff <= priv_head_in;
         priv_tail_ff <= priv_tail_in;
         pub_head_ff  <= pub_head_in;
         pub_tail_ff  <= pub_tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         occupancy_ff <= occupancy_in;
         deq_ok_ff    <= ram_ctrl.rd_en;
      end
   end

   assign wr_desc.region  = req_if.in_region;
   assign wr_desc.buffer  = req_if.in_buffer;
   assign wr_desc.address = req_if.in_address;
   assign wr_desc.length  = req_if.in_length;
   assign wr_desc.flags   = req_if.in_flags;

   drq_slot_ram #(
      .DEPTH  (MAX_SLOTS),
      .ADDR_W (PTR_W)
   ) u_slot_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .wr_addr (priv_head_ff),
      .wr_data (wr_desc),
      .rd_addr (priv_tail_ff),
      .rd_data (rd_desc)
   );

   // Drop the descriptor on anything but a successful dequeue
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.occupancy   = occupancy_ff;
   assign rsp_if.out_region  = deq_ok_ff ? rd_desc.region  : '0;
   assign rsp_if.out_buffer  = deq_ok_ff ? rd_desc.buffer  : '0;
   assign rsp_if.out_address = deq_ok_ff ? rd_desc.address : '0;
   assign rsp_if.out_length  = deq_ok_ff ? rd_desc.length  : '0;
   assign rsp_if.out_flags   = deq_ok_ff ? rd_desc.flags   : '0;

   a_csr_clears_pointers: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (priv_head_ff == '0) && (priv_tail_ff == '0)
                    && (pub_head_ff == '0) && (pub_tail_ff == '0))
      else $error("pointers not cleared after slot count write");

   a_pointers_in_ring: assert property (@(posedge clock) disable iff (reset)
      (head_ext < ring_n) && (tail_ext < ring_n)
      && (pub_head_ext < ring_n) && (pub_tail_ext < ring_n))
      else $error("ring pointer outside slot count");

   a_enqueue_advances: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_wr_en && (req_if.action == ACTION_ENQUEUE) && !ring_full
      |=> priv_head_ff != $past(priv_head_ff))
      else $error("successful enqueue did not advance head");

   a_failed_dequeue_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != STATUS_OK) |-> !deq_ok_ff)
      else $error("failed action carries a descriptor");

endmodule

/* src/drq_slot_ram.sv */
// Descriptor slot store: one write port, one read port with registered data.
module drq_slot_ram import drq_pkg::*; #(
   parameter int DEPTH  = MAX_SLOTS_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  ram_ctrl_type        ctrl,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  descriptor_type      wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output descriptor_type      rd_data
);

   descriptor_type mem_ff [DEPTH];
   descriptor_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Hold read data between reads so a stalled response stays put
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* test/descriptor_ring_queue_test.sv */
// Self-checking testbench for the descriptor ring queue: random handshakes, scoreboard, config.
module descriptor_ring_queue_test import drq_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned HOLD_CYCLES = 300;

   typedef struct {
      action_type     action;
      descriptor_type desc;
   } ring_request_type;

   typedef struct {
      status_type       status;
      descriptor_type   desc;
      logic [OCC_W-1:0] occupancy;
   } ring_reply_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_wr_en;
   logic [SLOT_COUNT_W-1:0] csr_wr_data;
   logic                    hold_trigger;

   drq_req_if req_bus ();
   drq_rsp_if rsp_bus ();

   descriptor_ring_queue dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus)
   );

   always #5ns clock = ~clock;

   // Ring model state
   logic [SLOT_COUNT_W-1:0] ring_count_reg;
   int unsigned             head_priv, tail_priv, head_pub, tail_pub;
   descriptor_type          slot_store [MAX_SLOTS_DEFAULT];

   ring_request_type queued_actions [$];
   ring_reply_type   awaited_replies [$];
   int unsigned      fail_count = 0;
   int unsigned      cycle_count = 0;

   function automatic int unsigned ring_size();
      int unsigned n;
      n = ring_count_reg;
      if (n < MIN_SLOTS) n = MIN_SLOTS;
      if (n > MAX_SLOTS_DEFAULT) n = MAX_SLOTS_DEFAULT;
      return n;
   endfunction

   function automatic int unsigned ring_dist(input int unsigned a, b, n);
      return (a + n - b) % n;
   endfunction

   // Advance the ring model by one action and return the reply it causes
   function automatic ring_reply_type apply_action(input ring_request_type r);
      ring_reply_type e;
      int unsigned n;
      n = ring_size();
      e.status = STATUS_OK;
      e.desc   = '0;
      case (r.action)
         ACTION_ENQUEUE: begin
            if (ring_dist(head_priv, tail_pub, n) == n - 1) begin
               e.status = STATUS_FULL;
            end else begin
               slot_store[head_priv] = r.desc;
               head_priv = (head_priv + 1) % n;
            end
         end
         ACTION_DEQUEUE: begin
            if (head_pub == tail_priv) begin
               e.status = STATUS_EMPTY;
            end else begin
               e.desc = slot_store[tail_priv];
               tail_priv = (tail_priv + 1) % n;
            end
         end
         ACTION_PUBLISH_HEAD: head_pub = head_priv;
         default: tail_pub = tail_priv;
      endcase
      e.occupancy = OCC_W'(ring_dist(head_pub, tail_priv, n));
      return e;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want, got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic descriptor_type random_descriptor();
      descriptor_type d;
      d.region  = $urandom;
      d.buffer  = $urandom;
      d.address = {$urandom, $urandom};
      d.length  = $urandom;
      d.flags   = {$urandom, $urandom};
      return d;
   endfunction

   function automatic void push_request(input action_type action, input descriptor_type desc);
      ring_request_type r;
      r.action = action;
      r.desc   = desc;
      queued_actions.push_back(r);
   endfunction

   // Driver
   ring_request_type offered;
   int unsigned      send_wait = 0;
   bit               send_calm = 1'b0;
   logic             next_valid;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.action     <= ACTION_ENQUEUE;
         req_bus.in_region  <= '0;
         req_bus.in_buffer  <= '0;
         req_bus.in_address <= '0;
         req_bus.in_length  <= '0;
         req_bus.in_flags   <= '0;
      end else begin
         next_valid = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            awaited_replies.push_back(apply_action(offered));
            next_valid = 1'b0;
            if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
            send_wait = send_calm ? 0 : $urandom_range(0, 9);
         end
         if (!next_valid) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (queued_actions.size() != 0) begin
               offered = queued_actions.pop_front();
               req_bus.action     <= offered.action;
               req_bus.in_region  <= offered.desc.region;
               req_bus.in_buffer  <= offered.desc.buffer;
               req_bus.in_address <= offered.desc.address;
               req_bus.in_length  <= offered.desc.length;
               req_bus.in_flags   <= offered.desc.flags;
               next_valid = 1'b1;
            end
         end
         req_bus.valid <= next_valid;
      end
   end

   // Monitor and scoreboard
   ring_reply_type want;
   int unsigned    take_wait = 0;
   int unsigned    hold_left = 0;
   bit             hold_done = 1'b0;
   bit             take_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (hold_left > 0) hold_left--;
         else if (take_wait > 0) take_wait--;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_replies.size() == 0) begin
               $error("response transfer with nothing expected");
               fail_count++;
            end else begin
               want = awaited_replies.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_bus.status));
               check_field("out_region", 64'(want.desc.region), 64'(rsp_bus.out_region));
               check_field("out_buffer", 64'(want.desc.buffer), 64'(rsp_bus.out_buffer));
               check_field("out_address", want.desc.address, rsp_bus.out_address);
               check_field("out_length", 64'(want.desc.length), 64'(rsp_bus.out_length));
               check_field("out_flags", want.desc.flags, rsp_bus.out_flags);
               check_field("occupancy", 64'(want.occupancy), 64'(rsp_bus.occupancy));
            end
            if ($urandom_range(0, 49) == 0) take_calm = !take_calm;
            take_wait = take_calm ? 0 : $urandom_range(0, 9);
         end
         // Back-pressure long enough to fill the response stage and stall requests
         if (hold_trigger && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         rsp_bus.ready <= (hold_left == 0 && take_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("descriptor_ring_queue_test failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (queued_actions.size() != 0 || req_bus.valid || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_ring_count(input logic [SLOT_COUNT_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ring_count_reg = value;
      head_priv = 0;
      tail_priv = 0;
      head_pub  = 0;
      tail_pub  = 0;
   endtask

   task automatic run_phase(input logic [SLOT_COUNT_W-1:0] value, input int unsigned items,
                            input bit fill, input bit stall);
      int unsigned n, made, k, m;
      bit          paused;
      write_ring_count(value);
      n = ring_size();
      made = 0;
      paused = 1'b0;
      if (fill) begin
         repeat (n + 1) push_request(ACTION_ENQUEUE, random_descriptor());
         push_request(ACTION_PUBLISH_HEAD, random_descriptor());
         repeat (n + 1) push_request(ACTION_DEQUEUE, random_descriptor());
         push_request(ACTION_PUBLISH_TAIL, random_descriptor());
      end
      if (stall) hold_trigger <= 1'b1;
      while (made < items) begin
         if (made >= items / 2 && !paused) begin
            wait_drained();
            paused = 1'b1;
         end
         if ($urandom_range(0, 4) == 0) begin
            push_request(action_type'($urandom_range(0, 3)), random_descriptor());
            made++;
         end else begin
            k = $urandom_range(1, (n < 11) ? n + 1 : 12);
            m = $urandom_range(0, k + 1);
            repeat (k) push_request(ACTION_ENQUEUE, random_descriptor());
            // Drop a publish now and then to leave the ring half-published
            if ($urandom_range(0, 5) != 0) push_request(ACTION_PUBLISH_HEAD, random_descriptor());
            repeat (m) push_request(ACTION_DEQUEUE, random_descriptor());
            if ($urandom_range(0, 5) != 0) push_request(ACTION_PUBLISH_TAIL, random_descriptor());
            made += k + m + 2;
         end
      end
      wait_drained();
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      hold_trigger       = 1'b0;
      ring_count_reg     = SLOT_COUNT_W'(SLOT_COUNT_RESET);
      head_priv = 0;
      tail_priv = 0;
      head_pub  = 0;
      tail_pub  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty ring, unpublished head, extreme descriptors
      push_request(ACTION_DEQUEUE, '1);
      push_request(ACTION_PUBLISH_HEAD, '1);
      push_request(ACTION_ENQUEUE, '1);
      push_request(ACTION_ENQUEUE, '0);
      push_request(ACTION_DEQUEUE, '0);
      push_request(ACTION_PUBLISH_HEAD, '0);
      push_request(ACTION_DEQUEUE, '0);
      push_request(ACTION_DEQUEUE, '0);
      push_request(ACTION_DEQUEUE, '0);
      push_request(ACTION_PUBLISH_TAIL, '0);
      wait_drained();

      // Slot count below the minimum: full ring, stale published tail, wrap
      write_ring_count('0);
      push_request(ACTION_ENQUEUE, {7{32'hAAAAAAAA}});
      push_request(ACTION_ENQUEUE, {7{32'h55555555}});
      push_request(ACTION_PUBLISH_HEAD, '0);
      push_request(ACTION_DEQUEUE, '0);
      push_request(ACTION_ENQUEUE, {7{32'h55555555}});
      push_request(ACTION_PUBLISH_TAIL, '0);
      push_request(ACTION_ENQUEUE, {7{32'h55555555}});
      push_request(ACTION_PUBLISH_HEAD, '0);
      push_request(ACTION_DEQUEUE, '0);
      push_request(ACTION_DEQUEUE, '0);
      wait_drained();

      run_phase(9'd256, 60, 1'b1, 1'b0);
      run_phase(9'd1, 100, 1'b0, 1'b0);
      run_phase(9'd2, 100, 1'b0, 1'b0);
      run_phase(9'd3, 100, 1'b0, 1'b0);
      run_phase(9'd4, 100, 1'b0, 1'b0);
      run_phase(9'd7, 100, 1'b0, 1'b0);
      run_phase(9'd16, 100, 1'b0, 1'b0);
      run_phase(9'd100, 100, 1'b0, 1'b1);
      run_phase(9'd255, 100, 1'b0, 1'b0);
      run_phase(SLOT_COUNT_W'($urandom_range(5, 250)), 100, 1'b0, 1'b0);
      run_phase(9'd257, 100, 1'b0, 1'b0);
      run_phase(9'd300, 100, 1'b0, 1'b0);
      run_phase(9'd511, 100, 1'b0, 1'b0);

      repeat (5) @(posedge clock);
      if (fail_count == 0)
         $display("descriptor_ring_queue_test passed");
      else
         $display("descriptor_ring_queue_test failed");
      $finish;
   end

endmodule

/* filelist.f */
src/drq_pkg.sv
src/drq_req_if.sv
src/drq_rsp_if.sv
src/drq_slot_ram.sv
src/descriptor_ring_queue.sv
test/descriptor_ring_queue_test.sv
